// ===== hw/rtl/nrpm_pkg.sv =====
// Package for the ntHash rolling pattern matcher: sizes, codes, seed types
// and the rotate and seed lookup helpers shared by the RTL modules.
// No dependencies.
`default_nettype none

package nrpm_pkg;

	localparam int MAX_PATTERN = 32;
	localparam int MAX_MATCHES = 1024;

	localparam int HASH_W = 32;
	localparam int ROT_W  = $clog2(HASH_W);
	localparam int SYM_W  = 8;
	localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
	localparam int IDX_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int OCC_W  = $clog2(MAX_MATCHES + 1);
	localparam int POS_W  = 32;
	localparam int CFG_IDX_W = 2;

	localparam logic [SYM_W-1:0] SYM_A = 8'h41;
	localparam logic [SYM_W-1:0] SYM_C = 8'h43;
	localparam logic [SYM_W-1:0] SYM_G = 8'h47;
	localparam logic [SYM_W-1:0] SYM_T = 8'h54;

	typedef enum logic [1:0] {
		ACT_CLEAR   = 2'd0,
		ACT_PATTERN = 2'd1,
		ACT_STREAM  = 2'd2
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SEED_A = 2'd0,
		REG_SEED_C = 2'd1,
		REG_SEED_G = 2'd2,
		REG_SEED_T = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [HASH_W-1:0] a;
		logic [HASH_W-1:0] c;
		logic [HASH_W-1:0] g;
		logic [HASH_W-1:0] t;
	} seeds_t;

	// rotate left; an amount of zero (full width) leaves the word as is
	function automatic logic [HASH_W-1:0] rotl(input logic [HASH_W-1:0] x,
			input logic [ROT_W-1:0] amt);
		logic [2*HASH_W-1:0] d;
		d = {x, x} << amt;
		return d[2*HASH_W-1:HASH_W];
	endfunction

	// bytes other than A, C, G, T map to a zero seed
	function automatic logic [HASH_W-1:0] seed_of(input seeds_t s,
			input logic [SYM_W-1:0] sym);
		logic [HASH_W-1:0] r;
		case (sym)
			SYM_A:   r = s.a;
			SYM_C:   r = s.c;
			SYM_G:   r = s.g;
			SYM_T:   r = s.t;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/nrpm_roll_hash.sv =====
// Rolling ntHash step: rotate the window hash, bring in the entering
// symbol's seed and cancel the leaving symbol's seed. Uses nrpm_pkg.
`default_nettype none

module nrpm_roll_hash (
	input  var nrpm_pkg::seeds_t                  seeds,
	input  var logic [nrpm_pkg::HASH_W-1:0]       hash_cur,
	input  var logic [nrpm_pkg::SYM_W-1:0]        sym_in,
	input  var logic [nrpm_pkg::SYM_W-1:0]        sym_out,
	input  var logic [nrpm_pkg::LEN_W-1:0]        len,
	input  var logic                              drop_en,
	output logic [nrpm_pkg::HASH_W-1:0]           hash_next
);
	import nrpm_pkg::*;

	logic [HASH_W-1:0] leave_term;

	// leaving seed sits rotated by the window length (mod hash width)
	assign leave_term = drop_en ? rotl(seed_of(seeds, sym_out), len[ROT_W-1:0]) : '0;
	assign hash_next  = rotl(hash_cur, ROT_W'(1)) ^ seed_of(seeds, sym_in) ^ leave_term;

endmodule

`default_nettype wire

// ===== hw/rtl/nthash_rolling_pattern_match.sv =====
// Top level of the ntHash rolling pattern matcher.
// Depends on nrpm_pkg and nrpm_roll_hash.
`default_nettype none

// Usage:
// - Input channel (in_valid/in_ready, action, symbol) carries one word per
//   item: clear the pattern and search state, append one pattern symbol,
//   or stream one sequence symbol.
// - Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the
//   seed words for A, C, G, T. cfg_ready is always high; write only while
//   the block is idle. A clear does not touch the seeds.
// - Output channel (out_valid/out_ready) gives one word for each streamed
//   symbol that completes a pattern-length window: hash hit, exact match,
//   collision, start position, match count and limit flag.
// - Latency: the result word is valid the cycle after its symbol is taken.
// - Throughput: one item per cycle when no result stalls. The hash roll,
//   the 32-byte window compare and the counter updates sit between the
//   state and output registers, so the only limit is the output register.
// - Stall: while a result waits and out_ready is low, in_ready drops and
//   the held word stays unchanged; in_ready follows out_ready, so a word can
//   be taken in the same cycle the previous result leaves.
// - Reset (arst_n low): seeds, pattern length, hashes and counts go to zero
//   and the output register empties. No clearing pass is needed: only
//   pattern and window bytes written since the last restart are ever read.
module nthash_rolling_pattern_match (
	input  var logic                              clk,
	input  var logic                              arst_n,

	input  var logic                              cfg_valid,
	output logic                                  cfg_ready,
	input  var logic [nrpm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  var logic [nrpm_pkg::HASH_W-1:0]       cfg_data,

	input  var logic                              in_valid,
	output logic                                  in_ready,
	input  var logic [1:0]                        action,
	input  var logic [nrpm_pkg::SYM_W-1:0]        symbol,

	output logic                                  out_valid,
	input  var logic                              out_ready,
	output logic                                  window_full,
	output logic                                  hash_hit,
	output logic                                  is_match,
	output logic                                  is_collision,
	output logic [nrpm_pkg::POS_W-1:0]            start_position,
	output logic [nrpm_pkg::OCC_W-1:0]            match_count,
	output logic                                  limit_reached
);
	import nrpm_pkg::*;

	// configuration
	seeds_t seeds_q;

	// search state
	logic [SYM_W-1:0]  pat_q [MAX_PATTERN];   // pat_q[0] = newest pattern byte
	logic [SYM_W-1:0]  win_q [MAX_PATTERN];   // win_q[0] = newest sequence byte
	logic [LEN_W-1:0]  len_q;
	logic [LEN_W-1:0]  fill_q;
	logic [HASH_W-1:0] phash_q;
	logic [HASH_W-1:0] whash_q;
	logic [POS_W-1:0]  seen_q;
	logic [OCC_W-1:0]  occ_q;

	// output register
	logic              out_valid_q;
	logic              hit_q, match_q, coll_q, limit_q;
	logic [POS_W-1:0]  pos_q;
	logic [OCC_W-1:0]  count_q;

	logic              in_acc;
	logic              cfg_acc;
	logic [LEN_W-1:0]  len_m1;
	logic              drop_en;
	logic [HASH_W-1:0] whash_n;
	logic [LEN_W-1:0]  fill_n;
	logic [POS_W-1:0]  seen_n;
	logic [MAX_PATTERN-1:0] eq_vec;
	logic              same;
	logic              hit;
	logic              counted;
	logic [OCC_W-1:0]  occ_n;
	logic              emit;

	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid & cfg_ready;
	assign in_ready  = ~out_valid_q | out_ready;
	assign in_acc    = in_valid & in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seeds_q <= '0;
		end else if (cfg_acc) begin
			case (cfg_index)
				REG_SEED_A: seeds_q.a <= cfg_data;
				REG_SEED_C: seeds_q.c <= cfg_data;
				REG_SEED_G: seeds_q.g <= cfg_data;
				REG_SEED_T: seeds_q.t <= cfg_data;
				default:    seeds_q.a <= seeds_q.a;
			endcase
		end
	end

	// leaving byte is the oldest one of the current window
	assign len_m1  = len_q - LEN_W'(1);
	assign drop_en = (fill_q >= len_q);

	nrpm_roll_hash u_roll (
		.seeds     (seeds_q),
		.hash_cur  (whash_q),
		.sym_in    (symbol),
		.sym_out   (win_q[len_m1[IDX_W-1:0]]),
		.len       (len_q),
		.drop_en   (drop_en),
		.hash_next (whash_n)
	);

	assign fill_n = (fill_q < LEN_W'(MAX_PATTERN)) ? fill_q + LEN_W'(1) : fill_q;
	assign seen_n = seen_q + POS_W'(1);

	// exact compare against the window after the shift, first len bytes only
	always_comb begin
		for (int j = 0; j < MAX_PATTERN; j++) begin
			if (j == 0)
				eq_vec[j] = (symbol == pat_q[0]) || (len_q <= LEN_W'(j));
			else
				eq_vec[j] = (win_q[j-1] == pat_q[j]) || (len_q <= LEN_W'(j));
		end
	end

	assign same    = &eq_vec;
	assign hit     = (whash_n == phash_q);
	assign counted = hit & same & (occ_q < OCC_W'(MAX_MATCHES));
	assign occ_n   = counted ? occ_q + OCC_W'(1) : occ_q;
	assign emit    = in_acc && (action == ACT_STREAM) && (len_q != '0) && (fill_n >= len_q);

	// control and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			fill_q  <= '0;
			phash_q <= '0;
			whash_q <= '0;
			seen_q  <= '0;
			occ_q   <= '0;
		end else if (in_acc) begin
			case (action)
				ACT_CLEAR: begin
					len_q   <= '0;
					fill_q  <= '0;
					phash_q <= '0;
					whash_q <= '0;
					seen_q  <= '0;
					occ_q   <= '0;
				end
				ACT_PATTERN: begin
					// append and restart the search; drop once the pattern is full
					if (len_q < LEN_W'(MAX_PATTERN)) begin
						len_q   <= len_q + LEN_W'(1);
						phash_q <= rotl(phash_q, ROT_W'(1)) ^ seed_of(seeds_q, symbol);
						fill_q  <= '0;
						whash_q <= '0;
						seen_q  <= '0;
						occ_q   <= '0;
					end
				end
				ACT_STREAM: begin
					seen_q <= seen_n;
					if (len_q != '0) begin
						whash_q <= whash_n;
						fill_q  <= fill_n;
						if (fill_n >= len_q)
							occ_q <= occ_n;
					end
				end
				default: begin
					len_q <= len_q;
				end
			endcase
		end
	end

	// byte shift lines; only bytes written since the last restart are read
	always_ff @(posedge clk) begin
		if (in_acc && action == ACT_PATTERN && len_q < LEN_W'(MAX_PATTERN)) begin
			pat_q[0] <= symbol;
			for (int j = 1; j < MAX_PATTERN; j++)
				pat_q[j] <= pat_q[j-1];
		end
		if (in_acc && action == ACT_STREAM && len_q != '0) begin
			win_q[0] <= symbol;
			for (int j = 1; j < MAX_PATTERN; j++)
				win_q[j] <= win_q[j-1];
		end
	end

	// output register: hold while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			hit_q   <= hit;
			match_q <= counted;
			coll_q  <= hit & ~same;
			pos_q   <= seen_n - POS_W'(len_q);
			count_q <= occ_n;
			limit_q <= (occ_n >= OCC_W'(MAX_MATCHES));
		end
	end

	assign out_valid      = out_valid_q;
	assign window_full    = 1'b1;
	assign hash_hit       = hit_q;
	assign is_match       = match_q;
	assign is_collision   = coll_q;
	assign start_position = pos_q;
	assign match_count    = count_q;
	assign limit_reached  = limit_q;

endmodule

`default_nettype wire
